@@ hw/rtl/karplus_strong_string_synth_assert.svh @@
// Assertion macros shared by the string synthesizer RTL.
`ifndef KARPLUS_STRONG_STRING_SYNTH_ASSERT_SVH
`define KARPLUS_STRONG_STRING_SYNTH_ASSERT_SVH
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define KSSS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("string synth check failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define KSSS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("string synth check failed");
`endif

@@ hw/rtl/ksss_pkg.sv @@
// Shared types, constants and helpers for the string synthesizer.
package ksss_pkg;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PLUCK = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_STOP  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_RATE      = 1'b0;
  localparam logic CFG_NOISE_LEN = 1'b1;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Period divider widths: the output rate shifted up by 20 over frequency.
  localparam int DIVIDEND_W = 38;
  localparam int DIVISOR_W  = 20;

  // Reciprocal of ten in Q0.19, exact for values below 2^18.
  localparam logic [MUL_B_W-1:0] RECIP_TEN = 18'd52429;

  typedef logic signed [MUL_P_W-1:0] prod_t;

  // Saturate a wide signed value to Q1.15.
  function automatic logic [15:0] sat16(input prod_t v);
    logic [15:0] r;
    if (v > prod_t'(32767)) r = 16'h7FFF;
    else if (v < -prod_t'(32768)) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/ksss_mul.sv @@
// Shared signed multiplier with a registered product.
module ksss_mul
  import ksss_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output prod_t                     p_r
);

  // One product per cycle, registered before any further use.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ hw/rtl/ksss_div.sv @@
// Bit-serial restoring divider for the string period.
module ksss_div
  import ksss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done_r,
  output logic [DIVIDEND_W-1:0] quo_r
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;

  // Bring down one dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIVIDEND_W);
        rem_r  <= '0;
        dvs_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        if (diff[DIVISOR_W]) begin
          rem_r <= trial[DIVISOR_W-1:0];
          quo_r <= {quo_r[DIVIDEND_W-2:0], 1'b0};
        end else begin
          rem_r <= diff[DIVISOR_W-1:0];
          quo_r <= {quo_r[DIVIDEND_W-2:0], 1'b1};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/karplus_strong_string_synth.sv @@
// Multi-voice plucked-string synthesizer top level with delay and noise memories.
// Per item: a load writes one noise word, a soft stop cuts the gain to a tenth and a tick
// writes back a gain-scaled sample; a pluck runs the bit-serial period divider unless the
// frequency is 0 and writes fill noise words (whole period plus one, at most DELAY_DEPTH).
// One item is worked at a time; a result waits in the output register.
// Synchronous active-low reset idles the block, silences all voices, loads register defaults.
`include "karplus_strong_string_synth_assert.svh"
module karplus_strong_string_synth
  import ksss_pkg::*;
#(
  parameter int STRING_COUNT = 6,
  parameter int DELAY_DEPTH  = 1024,
  parameter int NOISE_DEPTH  = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // string_index[2:0], frequency[22:3], feedback_gain[38:23], blend_factor[54:39],
  // noise_index[64:55], noise_value[80:65], zeros above
  input  logic [87:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sample[15:0]
  output logic [15:0] out_tdata,
  // string_active[0]
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
);

  localparam int SIW = (STRING_COUNT > 1) ? $clog2(STRING_COUNT) : 1;
  localparam int DW  = $clog2(DELAY_DEPTH);
  localparam int PW  = $clog2(DELAY_DEPTH + 1);
  localparam int NW  = $clog2(NOISE_DEPTH);
  localparam int AW  = $clog2(STRING_COUNT * DELAY_DEPTH);
  localparam int DEPTH_TOTAL = STRING_COUNT * DELAY_DEPTH;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_DIV, S_PER, S_FILL, S_T0, S_T1, S_T2,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_OUT, S_ST0, S_ST1
  } state_t;

  state_t state_r;

  // Latched item.
  logic [1:0]  op_r;
  logic [2:0]  s_r;
  logic [19:0] freq_r;
  logic [15:0] gain_in_r;
  logic [15:0] blend_in_r;
  logic [9:0]  nidx_r;
  logic [15:0] nval_r;

  // Configuration.
  logic [17:0] sr_r;
  logic [10:0] nl_r;

  // Per-voice state.
  logic          active_r [STRING_COUNT];
  logic [DW-1:0] rp_r     [STRING_COUNT];
  logic [PW-1:0] whole_r  [STRING_COUNT];
  logic [15:0]   frac_r   [STRING_COUNT];
  logic [15:0]   gain_r   [STRING_COUNT];
  logic [15:0]   blend_r  [STRING_COUNT];

  // Working registers.
  logic [NW-1:0] npos_r;
  logic [AW-1:0] base_r;
  logic [PW-1:0] fill_r;
  logic [PW-1:0] cnt_r;
  logic          pend_r;
  logic [DW-1:0] widx_r;
  logic [DW-1:0] p_r;
  logic [DW-1:0] nx_r;
  logic [15:0]   v0_r;
  logic [15:0]   v1_r;
  logic [MUL_A_W-1:0] acc_r;
  logic [15:0]   res_r;
  logic          out_tvalid_r;
  logic [15:0]   out_sample_r;
  logic          out_active_r;

  // Memories.
  logic [15:0] dly_mem [DEPTH_TOTAL];
  logic [15:0] noise_mem [NOISE_DEPTH];
  logic [15:0] dly_q_r;
  logic [15:0] noise_q_r;

  logic [SIW-1:0] sel;
  logic           s_ok;
  logic           out_free;
  logic           out_load;
  logic           noise_we;
  logic           dly_we;
  logic [AW-1:0]  dly_raddr;
  logic [AW-1:0]  dly_waddr;
  logic [15:0]    dly_wdata;
  logic [PW-1:0]  p_inc;
  logic [DW-1:0]  nx_comb;
  logic [12:0]    nlen;
  logic [12:0]    ptr_inc;
  logic [NW-1:0]  ptr_nxt;
  logic [21:0]    q_hi;
  logic           sat_per;
  logic [16:0]    diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  prod_t          mul_p;
  prod_t          samp_wide;
  prod_t          wb_wide;
  logic           div_start;
  logic           div_done;
  logic [DIVIDEND_W-1:0] div_q;

  assign sel        = SIW'(s_r);
  assign s_ok       = {29'd0, s_r} < STRING_COUNT;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_load   = ((state_r == S_M5) || (state_r == S_OUT)) && out_free;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_active_r;
  assign div_start  = (state_r == S_DEC) && (op_r == OP_PLUCK) && s_ok && (freq_r != '0);

  ksss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sr_r, 20'd0}),
    .divisor  (freq_r),
    .done_r   (div_done),
    .quo_r    (div_q)
  );

  ksss_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Noise length clamp and wrapping pointer step.
  always_comb begin
    if (nl_r == '0) nlen = 13'd1;
    else if ({2'd0, nl_r} > 13'(NOISE_DEPTH)) nlen = 13'(NOISE_DEPTH);
    else nlen = {2'd0, nl_r};
    ptr_inc = 13'(npos_r) + 13'd1;
    ptr_nxt = (ptr_inc >= nlen) ? '0 : NW'(ptr_inc);
  end

  // Next tap position, wrapping at the whole period.
  always_comb begin
    p_inc   = PW'(rp_r[sel]) + PW'(1);
    nx_comb = ((p_inc >= whole_r[sel]) || (p_inc >= PW'(DELAY_DEPTH))) ? '0 : DW'(p_inc);
  end

  // Period saturation from the divider quotient.
  always_comb begin
    q_hi    = div_q[DIVIDEND_W-1:16];
    sat_per = (freq_r == '0) || (q_hi > 22'(DELAY_DEPTH));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    diff  = {v1_r[15], v1_r} - {v0_r[15], v0_r};
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M0: begin
        mul_a = {{(MUL_A_W-17){diff[16]}}, diff};
        mul_b = {2'd0, frac_r[sel]};
      end
      S_M1: begin
        mul_a = {{(MUL_A_W-16){v0_r[15]}}, v0_r};
        mul_b = {2'd0, blend_r[sel]};
      end
      S_M2: begin
        mul_a = {{(MUL_A_W-16){v1_r[15]}}, v1_r};
        mul_b = {1'b0, 17'h10000 - {1'b0, blend_r[sel]}};
      end
      S_M4, S_M5: begin
        mul_a = acc_r;
        mul_b = {2'd0, gain_r[sel]};
      end
      S_ST0: begin
        mul_a = MUL_A_W'({1'b0, gain_r[sel]} + 17'd5);
        mul_b = RECIP_TEN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounded interpolation and rounded, gain-scaled write-back.
  always_comb begin
    samp_wide = ((mul_p + prod_t'(32768)) >>> 16) + prod_t'($signed(v0_r));
    wb_wide   = (mul_p + (prod_t'(1) <<< 31)) >>> 32;
  end

  // Delay and noise memory port control.
  always_comb begin
    noise_we  = (state_r == S_DEC) && (op_r == OP_LOAD) && ({3'd0, nidx_r} < 13'(NOISE_DEPTH));
    dly_we    = ((state_r == S_FILL) && pend_r) || ((state_r == S_M5) && out_free);
    dly_waddr = (state_r == S_M5) ? base_r + AW'(p_r) : base_r + AW'(widx_r);
    dly_wdata = (state_r == S_M5) ? sat16(wb_wide) : noise_q_r;
    case (state_r)
      S_T0:    dly_raddr = base_r + AW'(rp_r[sel]);
      S_T1:    dly_raddr = base_r + AW'(nx_r);
      default: dly_raddr = base_r + AW'(p_r);
    endcase
  end

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (dly_we) dly_mem[dly_waddr] <= dly_wdata;
    dly_q_r <= dly_mem[dly_raddr];
  end

  always_ff @(posedge clk) begin
    if (noise_we) noise_mem[NW'(nidx_r)] <= nval_r;
    noise_q_r <= noise_mem[npos_r];
  end

  // Sequencer, configuration registers, voice state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sr_r         <= 18'd48000;
      nl_r         <= 11'd1024;
      npos_r       <= '0;
      out_tvalid_r <= 1'b0;
      pend_r       <= 1'b0;
      cnt_r        <= '0;
      fill_r       <= '0;
      for (int i = 0; i < STRING_COUNT; i++) begin
        active_r[i] <= 1'b0;
        rp_r[i]     <= '0;
        whole_r[i]  <= '0;
        frac_r[i]   <= '0;
        gain_r[i]   <= '0;
        blend_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATE:      sr_r <= cfg_data;
          CFG_NOISE_LEN: nl_r <= cfg_data[10:0];
          default:       ;
        endcase
      end

      // A new result takes the output register; otherwise an accepted one leaves it.
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_tuser;
            s_r        <= in_tdata[2:0];
            freq_r     <= in_tdata[22:3];
            gain_in_r  <= in_tdata[38:23];
            blend_in_r <= in_tdata[54:39];
            nidx_r     <= in_tdata[64:55];
            nval_r     <= in_tdata[80:65];
            state_r    <= S_DEC;
          end
        end
        S_DEC: begin
          base_r <= AW'(sel) * AW'(DELAY_DEPTH);
          if (op_r == OP_LOAD || !s_ok) begin
            state_r <= S_IDLE;
          end else begin
            case (op_r)
              OP_PLUCK: state_r <= (freq_r == '0) ? S_PER : S_DIV;
              OP_TICK:  state_r <= active_r[sel] ? S_T0 : S_OUT;
              OP_STOP:  state_r <= S_ST0;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) state_r <= S_PER;
        end
        S_PER: begin
          if (sat_per) begin
            whole_r[sel] <= PW'(DELAY_DEPTH);
            frac_r[sel]  <= '0;
            fill_r       <= PW'(DELAY_DEPTH);
          end else begin
            whole_r[sel] <= PW'(q_hi);
            frac_r[sel]  <= div_q[15:0];
            fill_r       <= (PW'(q_hi) == PW'(DELAY_DEPTH)) ? PW'(DELAY_DEPTH)
                                                            : PW'(q_hi) + PW'(1);
          end
          rp_r[sel]     <= '0;
          gain_r[sel]   <= gain_in_r;
          blend_r[sel]  <= blend_in_r;
          active_r[sel] <= 1'b1;
          cnt_r         <= '0;
          pend_r        <= 1'b0;
          state_r       <= S_FILL;
        end
        S_FILL: begin
          // Read noise at the pointer; the word lands in the delay line next cycle.
          if (cnt_r < fill_r) begin
            npos_r <= ptr_nxt;
            widx_r <= DW'(cnt_r);
            cnt_r  <= cnt_r + PW'(1);
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) state_r <= S_IDLE;
          end
        end
        S_T0: begin
          p_r     <= rp_r[sel];
          nx_r    <= nx_comb;
          state_r <= S_T1;
        end
        S_T1: begin
          v0_r    <= dly_q_r;
          state_r <= S_T2;
        end
        S_T2: begin
          v1_r    <= dly_q_r;
          state_r <= S_M0;
        end
        S_M0: state_r <= S_M1;
        S_M1: begin
          res_r   <= sat16(samp_wide);
          state_r <= S_M2;
        end
        S_M2: begin
          acc_r   <= mul_p[MUL_A_W-1:0];
          state_r <= S_M3;
        end
        S_M3: begin
          acc_r   <= acc_r + mul_p[MUL_A_W-1:0];
          state_r <= S_M4;
        end
        S_M4: state_r <= S_M5;
        S_M5: begin
          if (out_free) begin
            out_sample_r <= res_r;
            out_active_r <= 1'b1;
            rp_r[sel]    <= nx_r;
            state_r      <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_sample_r <= '0;
            out_active_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        S_ST0: state_r <= S_ST1;
        S_ST1: begin
          gain_r[sel] <= mul_p[34:19];
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and pointer logic.
  `KSSS_ASSERT_NEXT(a_accept_decodes, in_tvalid && in_tready, state_r == S_DEC)
  `KSSS_ASSERT_NOW(a_npos_range, 1'b1, {1'b0, npos_r} < NOISE_DEPTH)
  `KSSS_ASSERT_NOW(a_dly_write_ctx, dly_we, state_r == S_FILL || state_r == S_M5)
  `KSSS_ASSERT_NOW(a_fill_bound, state_r == S_FILL, cnt_r <= fill_r)

endmodule
